// ----- rtl/vfa_pkg.sv -----
// Shared definitions for the three-dimensional fixed-point vector ALU.
// Holds the operation codes, status codes and default widths.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package vfa_pkg;

	// Default widths of the signed fixed-point format.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Number of vector components.
	localparam int VEC_N = 3;

	// Operation selector carried by each request.
	typedef enum logic [2:0] {
		FN_ADD    = 3'd0,
		FN_SUB    = 3'd1,
		FN_SCALE  = 3'd2,
		FN_DIV    = 3'd3,
		FN_DOT    = 3'd4,
		FN_CROSS  = 3'd5,
		FN_LENGTH = 3'd6,
		FN_NORM   = 3'd7
	} func_t;

	// Result status codes.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

endpackage

// ----- rtl/vfa_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit resolved per register stage.
// Carries an opaque side payload alongside each radicand.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module vfa_sqrt_pipe #(
	parameter int ROOT_W = 32,
	parameter int PASS_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2*ROOT_W-1:0]   rad,
	input  logic [PASS_W-1:0]     pass_in,
	output logic                  out_valid,
	output logic [ROOT_W-1:0]     root,
	output logic [PASS_W-1:0]     pass_out
);

	localparam int RW = ROOT_W + 2;
	localparam int TW = ROOT_W + 4;
	localparam int AW = 2 * ROOT_W;

	logic              vld_s  [ROOT_W];
	logic [RW-1:0]     rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [AW-1:0]     rad_s  [ROOT_W];
	logic [PASS_W-1:0] pas_s  [ROOT_W];

	// One stage per root bit: bring down two radicand bits and try a one.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic              vld_i;
		logic [RW-1:0]     rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [AW-1:0]     rad_i;
		logic [PASS_W-1:0] pas_i;
		logic [TW-1:0]     t;
		logic [TW-1:0]     trial;
		logic [TW-1:0]     diff;
		logic              ge;

		if (k == 0) begin : g_head
			assign vld_i  = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign pas_i  = pass_in;
		end else begin : g_tail
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign pas_i  = pas_s[k-1];
		end

		// Trial subtraction of four times the root plus one.
		always_comb begin
			t     = {rem_i, rad_i[AW-1 -: 2]};
			trial = {2'b00, root_i, 2'b01};
			ge    = (t >= trial);
			diff  = t - trial;
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		// Data of this stage.
		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[RW-1:0] : t[RW-1:0];
			root_s[k] <= {root_i[ROOT_W-2:0], ge};
			rad_s[k]  <= {rad_i[AW-3:0], 2'b00};
			pas_s[k]  <= pas_i;
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign pass_out  = pas_s[ROOT_W-1];

endmodule

// ----- rtl/vfa_div_pipe.sv -----
// Pipelined restoring divider for several lanes that share one divisor.
// One quotient bit per register stage; carries an opaque side payload.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps

module vfa_div_pipe #(
	parameter int NUM_W  = 48,
	parameter int DEN_W  = 32,
	parameter int LANES  = 3,
	parameter int PASS_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [DEN_W-1:0]            den,
	input  logic [PASS_W-1:0]           pass_in,
	output logic                        out_valid,
	output logic [LANES-1:0][NUM_W-1:0] quo,
	output logic [PASS_W-1:0]           pass_out
);

	logic                        vld_s [NUM_W];
	logic [LANES-1:0][NUM_W-1:0] num_s [NUM_W];
	logic [LANES-1:0][DEN_W-1:0] rem_s [NUM_W];
	logic [DEN_W-1:0]            den_s [NUM_W];
	logic [PASS_W-1:0]           pas_s [NUM_W];

	// One stage per quotient bit; the numerator shifts out as the quotient shifts in.
	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic                        vld_i;
		logic [LANES-1:0][NUM_W-1:0] num_i;
		logic [LANES-1:0][DEN_W-1:0] rem_i;
		logic [DEN_W-1:0]            den_i;
		logic [PASS_W-1:0]           pas_i;
		logic [LANES-1:0][NUM_W-1:0] num_o;
		logic [LANES-1:0][DEN_W-1:0] rem_o;

		if (k == 0) begin : g_head
			assign vld_i = in_valid;
			assign num_i = num;
			assign rem_i = '0;
			assign den_i = den;
			assign pas_i = pass_in;
		end else begin : g_tail
			assign vld_i = vld_s[k-1];
			assign num_i = num_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign pas_i = pas_s[k-1];
		end

		// Compare and subtract in every lane.
		always_comb begin
			logic [DEN_W:0] t;
			logic           ge;
			for (int l = 0; l < LANES; l++) begin
				t        = {rem_i[l], num_i[l][NUM_W-1]};
				ge       = (t >= {1'b0, den_i});
				rem_o[l] = ge ? DEN_W'(t - {1'b0, den_i}) : t[DEN_W-1:0];
				num_o[l] = {num_i[l][NUM_W-2:0], ge};
			end
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		// Data of this stage.
		always_ff @(posedge clk) begin
			num_s[k] <= num_o;
			rem_s[k] <= rem_o;
			den_s[k] <= den_i;
			pas_s[k] <= pas_i;
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quo       = num_s[NUM_W-1];
	assign pass_out  = pas_s[NUM_W-1];

endmodule

// ----- rtl/vector3_fixed_alu.sv -----
// Three-dimensional vector ALU on signed fixed point; every request yields one result.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Requests pass through the square-root pipeline (one root bit a stage) followed by
// the shared divider pipeline (one quotient bit a stage); all operations take the same path.
// Reset clears only the valid bits; no result is produced for requests in flight.
`timescale 1ns / 1ps

module vector3_fixed_alu
	import vfa_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] ax,
	input  logic signed [DATA_WIDTH-1:0] ay,
	input  logic signed [DATA_WIDTH-1:0] az,
	input  logic signed [DATA_WIDTH-1:0] bx,
	input  logic signed [DATA_WIDTH-1:0] by_comp,
	input  logic signed [DATA_WIDTH-1:0] bz,
	input  logic signed [DATA_WIDTH-1:0] scalar_in,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] rx,
	output logic signed [DATA_WIDTH-1:0] ry,
	output logic signed [DATA_WIDTH-1:0] rz,
	output logic signed [DATA_WIDTH-1:0] rs,
	output logic [1:0]                   status
);

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int VW  = 2 * W + 2;
	localparam int QW  = W + F;
	localparam int P1W = 8 * W + 5;
	localparam int P2W = 7 * W + 9;
	localparam int LAT = 2 * W + F + 5;

	localparam logic signed [VW-1:0] RND   = (VW'(1) << F) - VW'(1);
	localparam logic signed [VW-1:0] ZEROV = '0;
	localparam logic signed [VW-1:0] MAXV  = (VW'(1) << (W - 1)) - VW'(1);
	localparam logic signed [VW-1:0] MINV  = ~MAXV;
	localparam logic [W-1:0]         MAXW  = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0]         MINW  = {1'b1, {(W - 1){1'b0}}};
	localparam logic [QW-1:0]        LIMQ  = QW'(1) << (W - 1);

	// Truncate toward zero by the fraction width when asked, then clamp; top bit flags a clamp.
	function automatic logic [W:0] trunc_sat(input logic signed [VW-1:0] v, input logic shf);
		logic signed [VW-1:0] t;
		logic [W:0]           r;
		t = v;
		if (shf) begin
			t = v + (v[VW-1] ? RND : ZEROV);
			t = t >>> F;
		end
		if (t > MAXV) begin
			r = {1'b1, MAXW};
		end else if (t < MINV) begin
			r = {1'b1, MINW};
		end else begin
			r = {1'b0, t[W-1:0]};
		end
		return r;
	endfunction

	logic accept;

	// Stage 1: captured request.
	logic                v_s1;
	func_t               fn_s1;
	logic signed [W-1:0] a_s1 [VEC_N];
	logic signed [W-1:0] b_s1 [VEC_N];
	logic signed [W-1:0] sc_s1;

	// Stage 2: products and component sums.
	logic                v_s2;
	func_t               fn_s2;
	logic signed [W-1:0] a_s2 [VEC_N];
	logic signed [W-1:0] sc_s2;
	logic signed [PW-1:0] prod_s2 [2*VEC_N];
	logic signed [W:0]   as_s2 [VEC_N];

	// Stage 3: exact wide values.
	logic                v_s3;
	func_t               fn_s3;
	logic signed [W-1:0] a_s3 [VEC_N];
	logic signed [W-1:0] sc_s3;
	logic signed [VW-1:0] val_s3 [VEC_N];
	logic                shf_s3;

	// Stage 4: packed results of the direct operations.
	logic                v_s4;
	func_t               fn_s4;
	logic signed [W-1:0] a_s4 [VEC_N];
	logic signed [W-1:0] sc_s4;
	logic [W-1:0]        r_s4 [VEC_N];
	logic [W-1:0]        rs_s4;
	logic [1:0]          st_s4;
	logic [PW-1:0]       sq_s4;

	logic signed [W-1:0]  ml [2*VEC_N];
	logic signed [W-1:0]  mr [2*VEC_N];
	logic signed [VW-1:0] val_n [VEC_N];
	logic                 shf_n;
	logic [W:0]           ts [VEC_N];
	logic [W-1:0]         r_n [VEC_N];
	logic [W-1:0]         rs_n;
	logic [1:0]           st_n;

	// The square-root stage.
	logic [P1W-1:0] p1_in;
	logic [P1W-1:0] p1_out;
	logic           v_sq;
	logic [W-1:0]   root;
	logic [2:0]     fn1_bits;
	func_t          fn1;
	logic [W-1:0]   r1 [VEC_N];
	logic [W-1:0]   rs1;
	logic [1:0]     st1;
	logic [W-1:0]   a1 [VEC_N];
	logic [W-1:0]   sc1;

	// Divider entry.
	logic [VEC_N-1:0][QW-1:0] num1;
	logic [W-1:0]             den1;
	logic [VEC_N-1:0]         neg1;
	logic                     fail1;
	logic [W-1:0]             rs1n;
	logic [1:0]               st1n;
	logic [W-1:0]             sc_mag;
	logic [W-1:0]             a_mag;
	logic                     is_div;

	// The divider stage.
	logic [P2W-1:0]           p2_in;
	logic [P2W-1:0]           p2_out;
	logic                     v_dv;
	logic [VEC_N-1:0][QW-1:0] quo;
	logic [2:0]               fn2_bits;
	func_t                    fn2;
	logic [W-1:0]             r2 [VEC_N];
	logic [W-1:0]             rs2;
	logic [1:0]               st2;
	logic [W-1:0]             a2 [VEC_N];
	logic [VEC_N-1:0]         neg2;
	logic                     fail2;

	logic [W-1:0] q_val [VEC_N];
	logic         q_sat;
	logic [W-1:0] o_r [VEC_N];
	logic [W-1:0] o_rs;
	logic [1:0]   o_st;

	// The pipeline never refuses a request.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Multiplier operand selection; the last three are used by the cross product only.
	always_comb begin
		for (int i = 0; i < VEC_N; i++) begin
			ml[i] = a_s1[i];
			mr[i] = a_s1[i];
		end
		ml[3] = a_s1[2];
		mr[3] = b_s1[1];
		ml[4] = a_s1[0];
		mr[4] = b_s1[2];
		ml[5] = a_s1[1];
		mr[5] = b_s1[0];
		case (fn_s1)
			FN_SCALE: begin
				for (int i = 0; i < VEC_N; i++) begin
					mr[i] = sc_s1;
				end
			end
			FN_DOT: begin
				for (int i = 0; i < VEC_N; i++) begin
					mr[i] = b_s1[i];
				end
			end
			FN_CROSS: begin
				ml[0] = a_s1[1];
				mr[0] = b_s1[2];
				ml[1] = a_s1[2];
				mr[1] = b_s1[0];
				ml[2] = a_s1[0];
				mr[2] = b_s1[1];
			end
			default: begin
			end
		endcase
	end

	// Wide values: sums or differences, scaled products, differences of cross terms, or the sum of three products.
	always_comb begin
		for (int i = 0; i < VEC_N; i++) begin
			val_n[i] = '0;
		end
		shf_n = 1'b1;
		case (fn_s2)
			FN_ADD, FN_SUB: begin
				for (int i = 0; i < VEC_N; i++) begin
					val_n[i] = VW'(as_s2[i]);
				end
				shf_n = 1'b0;
			end
			FN_SCALE: begin
				for (int i = 0; i < VEC_N; i++) begin
					val_n[i] = VW'(prod_s2[i]);
				end
			end
			FN_CROSS: begin
				for (int i = 0; i < VEC_N; i++) begin
					val_n[i] = VW'(prod_s2[i]) - VW'(prod_s2[i+VEC_N]);
				end
			end
			default: begin
				val_n[0] = VW'(prod_s2[0]) + VW'(prod_s2[1]) + VW'(prod_s2[2]);
			end
		endcase
	end

	// Truncation and clamping of the direct operations.
	always_comb begin
		for (int i = 0; i < VEC_N; i++) begin
			ts[i]  = trunc_sat(val_s3[i], shf_s3);
			r_n[i] = '0;
		end
		rs_n = '0;
		st_n = ST_OK;
		case (fn_s3)
			FN_ADD, FN_SUB, FN_SCALE, FN_CROSS: begin
				for (int i = 0; i < VEC_N; i++) begin
					r_n[i] = ts[i][W-1:0];
				end
				if (ts[0][W] || ts[1][W] || ts[2][W]) begin
					st_n = ST_SAT;
				end
			end
			FN_DOT: begin
				rs_n = ts[0][W-1:0];
				if (ts[0][W]) begin
					st_n = ST_SAT;
				end
			end
			default: begin
			end
		endcase
	end

	// Front stage data registers.
	always_ff @(posedge clk) begin
		fn_s1    <= func_t'(func);
		a_s1[0]  <= ax;
		a_s1[1]  <= ay;
		a_s1[2]  <= az;
		b_s1[0]  <= bx;
		b_s1[1]  <= by_comp;
		b_s1[2]  <= bz;
		sc_s1    <= scalar_in;

		fn_s2 <= fn_s1;
		sc_s2 <= sc_s1;
		for (int i = 0; i < VEC_N; i++) begin
			a_s2[i] <= a_s1[i];
			if (fn_s1 == FN_SUB) begin
				as_s2[i] <= {a_s1[i][W-1], a_s1[i]} - {b_s1[i][W-1], b_s1[i]};
			end else begin
				as_s2[i] <= {a_s1[i][W-1], a_s1[i]} + {b_s1[i][W-1], b_s1[i]};
			end
		end
		for (int j = 0; j < 2 * VEC_N; j++) begin
			prod_s2[j] <= ml[j] * mr[j];
		end

		fn_s3  <= fn_s2;
		sc_s3  <= sc_s2;
		shf_s3 <= shf_n;
		for (int i = 0; i < VEC_N; i++) begin
			a_s3[i]   <= a_s2[i];
			val_s3[i] <= val_n[i];
		end

		fn_s4 <= fn_s3;
		sc_s4 <= sc_s3;
		rs_s4 <= rs_n;
		st_s4 <= st_n;
		sq_s4 <= val_s3[0][PW-1:0];
		for (int i = 0; i < VEC_N; i++) begin
			a_s4[i] <= a_s3[i];
			r_s4[i] <= r_n[i];
		end
	end

	// Square root of the sum of squares, with everything else riding alongside.
	assign p1_in = {fn_s4, r_s4[0], r_s4[1], r_s4[2], rs_s4, st_s4,
		a_s4[0], a_s4[1], a_s4[2], sc_s4};

	vfa_sqrt_pipe #(
		.ROOT_W (W),
		.PASS_W (P1W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rad       (sq_s4),
		.pass_in   (p1_in),
		.out_valid (v_sq),
		.root      (root),
		.pass_out  (p1_out)
	);

	assign {fn1_bits, r1[0], r1[1], r1[2], rs1, st1, a1[0], a1[1], a1[2], sc1} = p1_out;
	assign fn1 = func_t'(fn1_bits);

	// Divisor choice, magnitudes and signs for the divider; the length result is packed here.
	always_comb begin
		is_div = (fn1 == FN_DIV);
		sc_mag = sc1[W-1] ? (~sc1 + W'(1)) : sc1;
		den1   = is_div ? sc_mag : root;
		for (int i = 0; i < VEC_N; i++) begin
			a_mag   = a1[i][W-1] ? (~a1[i] + W'(1)) : a1[i];
			num1[i] = {a_mag, {F{1'b0}}};
			neg1[i] = a1[i][W-1] ^ (is_div & sc1[W-1]);
		end
		fail1 = (is_div || (fn1 == FN_NORM)) && (den1 == '0);
		rs1n  = rs1;
		st1n  = st1;
		if (fn1 == FN_LENGTH) begin
			rs1n = root[W-1] ? MAXW : root;
			st1n = root[W-1] ? ST_SAT : ST_OK;
		end
	end

	assign p2_in = {fn1_bits, r1[0], r1[1], r1[2], rs1n, st1n,
		a1[0], a1[1], a1[2], neg1, fail1};

	vfa_div_pipe #(
		.NUM_W  (QW),
		.DEN_W  (W),
		.LANES  (VEC_N),
		.PASS_W (P2W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_sq),
		.num       (num1),
		.den       (den1),
		.pass_in   (p2_in),
		.out_valid (v_dv),
		.quo       (quo),
		.pass_out  (p2_out)
	);

	assign {fn2_bits, r2[0], r2[1], r2[2], rs2, st2, a2[0], a2[1], a2[2], neg2, fail2} = p2_out;
	assign fn2 = func_t'(fn2_bits);

	// Signing and clamping of the quotients, then the final result selection.
	always_comb begin
		logic s;
		q_sat = 1'b0;
		for (int i = 0; i < VEC_N; i++) begin
			s = neg2[i] ? (quo[i] > LIMQ) : (quo[i] >= LIMQ);
			if (s) begin
				q_val[i] = neg2[i] ? MINW : MAXW;
			end else if (neg2[i]) begin
				q_val[i] = ~quo[i][W-1:0] + W'(1);
			end else begin
				q_val[i] = quo[i][W-1:0];
			end
			q_sat = q_sat | s;
		end
		for (int i = 0; i < VEC_N; i++) begin
			o_r[i] = r2[i];
		end
		o_rs = rs2;
		o_st = st2;
		if (fail2) begin
			for (int i = 0; i < VEC_N; i++) begin
				o_r[i] = a2[i];
			end
			o_rs = '0;
			o_st = ST_ZERO;
		end else if ((fn2 == FN_DIV) || (fn2 == FN_NORM)) begin
			for (int i = 0; i < VEC_N; i++) begin
				o_r[i] = q_val[i];
			end
			o_rs = '0;
			o_st = q_sat ? ST_SAT : ST_OK;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_dv;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		rx     <= o_r[0];
		ry     <= o_r[1];
		rz     <= o_r[2];
		rs     <= o_rs;
		status <= o_st;
	end

	// Every accepted request produces its strobe after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result strobe missing after the fixed latency");

	// A strobed result never carries an unused status code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK) || (status == ST_ZERO) || (status == ST_SAT))
		else $error("undefined status code on a result");

	// A zero-divisor result leaves the scalar output cleared.
	a_zero_rs: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_ZERO)) |-> (rs == '0))
		else $error("scalar result not cleared on a zero divisor");

endmodule
